>>> rtl/dsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force package
// Shared constants and the pipeline control bundle.
// ----------------------------------------------------------------------------
package dsf_pkg;

    localparam int SOFT_WIDTH   = 21;
    localparam int WRAP_LOG     = 64;
    localparam int DAMP_CAP_LOG = 45;

    localparam logic [SOFT_WIDTH-1:0] SOFT_RESET = SOFT_WIDTH'(1);
    localparam logic [WRAP_LOG-1:0]   DAMP_CAP   = WRAP_LOG'(1) << DAMP_CAP_LOG;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

>>> rtl/dsf_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring item channel
// Valid/ready channel carrying one spring description per item.
// ----------------------------------------------------------------------------
interface dsf_item_if #(
    parameter int DATA_WIDTH = 32,
    parameter int ID_WIDTH   = 16
);
    logic                         valid;
    logic                         ready;
    logic [ID_WIDTH-1:0]          spring_id;
    logic signed [DATA_WIDTH-1:0] sep_x;
    logic signed [DATA_WIDTH-1:0] sep_y;
    logic signed [DATA_WIDTH-1:0] sep_z;
    logic signed [DATA_WIDTH-1:0] relvel_x;
    logic signed [DATA_WIDTH-1:0] relvel_y;
    logic signed [DATA_WIDTH-1:0] relvel_z;
    logic [DATA_WIDTH-2:0]        mass_a;
    logic [DATA_WIDTH-2:0]        mass_b;
    logic [DATA_WIDTH-2:0]        stiffness;
    logic [DATA_WIDTH-2:0]        damping;
    logic [DATA_WIDTH-2:0]        rest_len;

    modport source (
        output valid, spring_id, sep_x, sep_y, sep_z, relvel_x, relvel_y, relvel_z,
               mass_a, mass_b, stiffness, damping, rest_len,
        input  ready
    );
    modport sink (
        input  valid, spring_id, sep_x, sep_y, sep_z, relvel_x, relvel_y, relvel_z,
               mass_a, mass_b, stiffness, damping, rest_len,
        output ready
    );
endinterface

>>> rtl/dsf_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring force result channel
// Valid/ready channel carrying one force result per item.
// ----------------------------------------------------------------------------
interface dsf_result_if #(
    parameter int DATA_WIDTH = 32,
    parameter int ID_WIDTH   = 16
);
    logic                         valid;
    logic                         ready;
    logic [ID_WIDTH-1:0]          spring_tag;
    logic signed [DATA_WIDTH-1:0] force_x;
    logic signed [DATA_WIDTH-1:0] force_y;
    logic signed [DATA_WIDTH-1:0] force_z;
    logic signed [DATA_WIDTH-1:0] lvec_x;
    logic signed [DATA_WIDTH-1:0] lvec_y;
    logic signed [DATA_WIDTH-1:0] lvec_z;
    logic [DATA_WIDTH-1:0]        soft_length;
    logic                         saturated;

    modport source (
        output valid, spring_tag, force_x, force_y, force_z, lvec_x, lvec_y, lvec_z,
               soft_length, saturated,
        input  ready
    );
    modport sink (
        input  valid, spring_tag, force_x, force_y, force_z, lvec_x, lvec_y, lvec_z,
               soft_length, saturated,
        output ready
    );
endinterface

>>> rtl/dsf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor of the root, side data delayed alongside.
// ----------------------------------------------------------------------------
module dsf_sqrt
    import dsf_pkg::*;
#(
    parameter int RW = 32,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_pipe_ctl       i_ctl,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    logic [RW:0]     r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];
    logic [SW-1:0]   r_side [RW];
    logic [RW-1:0]   r_vld;

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic [RW:0]     src_rem;
        logic [RW-1:0]   src_root;
        logic [2*RW-1:0] src_rad;
        logic [SW-1:0]   src_side;
        logic            src_vld;
        logic [RW+2:0]   acc;
        logic [RW+2:0]   trial;
        logic            fit;

        if (s == 0) begin : g_first
            assign src_rem  = '0;
            assign src_root = '0;
            assign src_rad  = i_rad;
            assign src_side = i_side;
            assign src_vld  = i_ctl.vld;
        end else begin : g_next
            assign src_rem  = r_rem[s-1];
            assign src_root = r_root[s-1];
            assign src_rad  = r_rad[s-1];
            assign src_side = r_side[s-1];
            assign src_vld  = r_vld[s-1];
        end

        assign acc   = {src_rem, src_rad[2*RW-1 -: 2]};
        assign trial = {1'b0, src_root, 2'b01};
        assign fit   = acc >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[s]  <= fit ? (RW+1)'(acc - trial) : acc[RW:0];
                r_root[s] <= {src_root[RW-2:0], fit};
                r_rad[s]  <= {src_rad[2*RW-3:0], 2'b00};
                r_side[s] <= src_side;
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_side[RW-1];

endmodule

>>> rtl/dsf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined multi-lane divider
// Restoring division, one quotient bit per stage, all lanes in lockstep.
// The numerator bits above the quotient width must stay below the divisor.
// ----------------------------------------------------------------------------
module dsf_div
    import dsf_pkg::*;
#(
    parameter int LANES = 1,
    parameter int NW    = 64,
    parameter int DW    = 33,
    parameter int QW    = 32,
    parameter int SW    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_pipe_ctl                   i_ctl,
    input  logic [LANES-1:0][NW-1:0]    i_num,
    input  logic [LANES-1:0][DW-1:0]    i_den,
    input  logic [SW-1:0]               i_side,
    output logic                        o_vld,
    output logic [LANES-1:0][QW-1:0]    o_quo,
    output logic [SW-1:0]               o_side
);

    logic [LANES-1:0][DW+QW-1:0] r_work [QW];
    logic [LANES-1:0][DW-1:0]    r_den  [QW];
    logic [SW-1:0]               r_side [QW];
    logic [QW-1:0]               r_vld;

    for (genvar s = 0; s < QW; s++) begin : g_stage
        logic [LANES-1:0][DW+QW-1:0] src_work;
        logic [LANES-1:0][DW-1:0]    src_den;
        logic [SW-1:0]               src_side;
        logic                        src_vld;
        logic [LANES-1:0][DW+QW-1:0] n_work;

        if (s == 0) begin : g_first
            for (genvar l = 0; l < LANES; l++) begin : g_load
                assign src_work[l] = (DW+QW)'(i_num[l]);
            end
            assign src_den  = i_den;
            assign src_side = i_side;
            assign src_vld  = i_ctl.vld;
        end else begin : g_next
            assign src_work = r_work[s-1];
            assign src_den  = r_den[s-1];
            assign src_side = r_side[s-1];
            assign src_vld  = r_vld[s-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DW:0] part;
            logic        fit;
            assign part      = src_work[l][DW+QW-1:QW-1];
            assign fit       = part >= {1'b0, src_den[l]};
            assign n_work[l] = {fit ? DW'(part - {1'b0, src_den[l]}) : part[DW-1:0],
                                src_work[l][QW-2:0], fit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= src_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_work[s] <= n_work;
                r_den[s]  <= src_den;
                r_side[s] <= src_side;
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_work[QW-1][l][QW-1:0];
    end
    assign o_vld  = r_vld[QW-1];
    assign o_side = r_side[QW-1];

endmodule

>>> rtl/damped_spring_force_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force unit
// Hookean spring force with optional damping along the spring axis, fixed
// point, saturated, one spring per item.
//
//   channel   | dir | handshake         | contents
//   ----------+-----+-------------------+----------------------------------
//   i_item    | in  | valid/ready       | spring id, separation, velocity,
//             |     |                   | masses, stiffness, damping, rest
//   o_result  | out | valid/ready       | tag, force, length vector, length
//   i_cfg_*   | in  | write enable only | softening length
//
// One item enters per cycle while the output is not stalled; each passes
// through the root pipeline, the two divider pipelines and the multiplier
// stages. Reset is synchronous and clears all valid bits and the softening
// length (to one LSB). A stall at the output freezes every stage together;
// items are held in place, none dropped.
// ----------------------------------------------------------------------------
module damped_spring_force_unit
    import dsf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 20,
    parameter int ID_WIDTH   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dsf_item_if.sink              i_item,
    dsf_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [SOFT_WIDTH-1:0] i_cfg_wdata
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int FW = ((2*W > WRAP_LOG) ? 2*W : WRAP_LOG) + 2;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [2:0][W-1:0]     d;
        logic [W-1:0]          soft_o;
        logic                  sat_len;
        logic                  s_neg;
        logic                  dv_neg;
    } t_tag;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [2:0][W-1:0]     d;
        logic [2:0][W-1:0]     v;
        logic [W-2:0]          ma;
        logic [W-2:0]          mb;
        logic [W-2:0]          ks;
        logic [W-2:0]          gam;
        logic [W-2:0]          rest;
    } t_a;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [2:0][W-1:0]     d;
        logic [2:0][W-1:0]     dm;
        logic [2:0][2*W-1:0]   sq;
        logic [2:0][2*W-1:0]   pv;
        logic [2:0]            sgn;
        logic [2*W-3:0]        mprod;
        logic [W-1:0]          msum;
        logic [W-2:0]          ks;
        logic [W-2:0]          gam;
        logic [W-2:0]          rest;
    } t_b;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [2:0][W-1:0]     d;
        logic [2:0][W-1:0]     dm;
        logic [2*W-1:0]        pos;
        logic [2*W-1:0]        neg;
        logic [2*W-3:0]        mprod;
        logic [W-1:0]          msum;
        logic [W-2:0]          ks;
        logic [W-2:0]          gam;
        logic [W-2:0]          rest;
    } t_c;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][W-1:0]     dm;
        logic [W:0]            len;
        logic [W:0]            s_mag;
        logic [2*W-1:0]        dv_mag;
        logic [2*W-3:0]        mprod;
        logic [W-1:0]          msum;
        logic [W-2:0]          ks;
        logic [W-2:0]          gam;
    } t_d;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][W-1:0]     dm;
        logic [W:0]            len;
        logic [2*W-1:0]        q;
        logic [2*W-1:0]        dv_mag;
        logic [2*W-3:0]        mprod;
        logic [W-1:0]          msum;
        logic [W-2:0]          gam;
    } t_e;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][W-1:0]     dm;
        logic [W:0]            len;
        logic [2:0][2*W-1:0]   hi;
        logic [2:0][2*W-1:0]   lo;
        logic [2*W-1:0]        dv_mag;
        logic [2*W-3:0]        mprod;
        logic [W-1:0]          msum;
        logic [W-2:0]          gam;
    } t_f;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][W-1:0]     dm;
        logic [W:0]            len;
        logic [2:0][3*W-1:0]   n1;
        logic [2*W-1:0]        dv_mag;
        logic [2*W-3:0]        mprod;
        logic [W-1:0]          msum;
        logic [W-2:0]          gam;
    } t_g;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0][W-1:0]     dm;
        logic [W:0]            len;
        logic                  msum_zero;
        logic [W-2:0]          gam;
    } t_s1;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0]            dm_zero;
        logic                  len_zero;
        logic                  gam_nz;
        logic [W:0]            len;
        logic [2:0][2*W-1:0]   p;
        logic [2*W-3:0]        gprod;
        logic [2:0][2*W:0]     rdm;
    } t_h;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0]            dm_zero;
        logic                  len_zero;
        logic                  gam_nz;
        logic [2:0][2*W-1:0]   p;
        logic [2*W-1:0]        g;
    } t_s2;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0]            dm_zero;
        logic                  len_zero;
        logic                  gam_nz;
        logic [2:0][2*W-1:0]   p;
        logic [2:0][2*W:0]     glo;
        logic [2:0][2*W:0]     ghi;
    } t_j;

    typedef struct packed {
        t_tag                  tag;
        logic [2:0]            dm_zero;
        logic                  len_zero;
        logic                  gam_nz;
        logic [2:0][2*W-1:0]   p;
        logic [2:0][WRAP_LOG-1:0] dd;
    } t_k;

    typedef struct packed {
        logic [ID_WIDTH-1:0]   id;
        logic [2:0][W-1:0]     frc;
        logic [2:0][W-1:0]     lvec;
        logic [W-1:0]          soft_o;
        logic                  sat;
    } t_out;

    logic                  en;
    logic [SOFT_WIDTH-1:0] r_soft;

    t_a   r_a,   n_a;
    t_b   r_b,   n_b;
    t_c   r_c,   sq_side;
    t_d   r_d,   n_d;
    t_e   r_e,   n_e;
    t_f   r_f,   n_f;
    t_g   r_g,   n_g;
    t_s1  d1_side_in, d1_side;
    t_h   r_h,   n_h;
    t_s2  d2_side_in, d2_side;
    t_j   r_j,   n_j;
    t_k   r_k,   n_k;
    t_out r_out, n_out;

    logic [2*W-1:0] r_c_sq;
    logic [2*W-1:0] n_c_sq;
    t_c             n_c;

    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    logic r_h_vld, r_j_vld, r_k_vld, r_out_vld;
    logic sq_vld, d1_vld, d2_vld;

    logic [W-1:0]                sq_root;
    logic [$bits(t_c)-1:0]       sq_side_raw;
    logic [4:0][3*W-1:0]         d1_num;
    logic [4:0][W:0]             d1_den;
    logic [4:0][2*W-1:0]         d1_quo;
    logic [$bits(t_s1)-1:0]      d1_side_raw;
    logic [2:0][2*W:0]           d2_num;
    logic [2:0][W:0]             d2_den;
    logic [2:0][W:0]             d2_quo;
    logic [$bits(t_s2)-1:0]      d2_side_raw;

    assign en           = !r_out_vld || o_result.ready;
    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft <= SOFT_RESET;
        end else if (i_cfg_we) begin
            r_soft <= i_cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_e_vld   <= 1'b0;
            r_f_vld   <= 1'b0;
            r_g_vld   <= 1'b0;
            r_h_vld   <= 1'b0;
            r_j_vld   <= 1'b0;
            r_k_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= i_item.valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_d_vld   <= sq_vld;
            r_e_vld   <= r_d_vld;
            r_f_vld   <= r_e_vld;
            r_g_vld   <= r_f_vld;
            r_h_vld   <= d1_vld;
            r_j_vld   <= d2_vld;
            r_k_vld   <= r_j_vld;
            r_out_vld <= r_k_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_c    <= n_c;
            r_c_sq <= n_c_sq;
            r_d    <= n_d;
            r_e    <= n_e;
            r_f    <= n_f;
            r_g    <= n_g;
            r_h    <= n_h;
            r_j    <= n_j;
            r_k    <= n_k;
            r_out  <= n_out;
        end
    end

    // capture
    always_comb begin
        n_a.id   = i_item.spring_id;
        n_a.d[0] = i_item.sep_x;
        n_a.d[1] = i_item.sep_y;
        n_a.d[2] = i_item.sep_z;
        n_a.v[0] = i_item.relvel_x;
        n_a.v[1] = i_item.relvel_y;
        n_a.v[2] = i_item.relvel_z;
        n_a.ma   = i_item.mass_a;
        n_a.mb   = i_item.mass_b;
        n_a.ks   = i_item.stiffness;
        n_a.gam  = i_item.damping;
        n_a.rest = i_item.rest_len;
    end

    // magnitudes, squares, dot terms, mass product and mass sum
    always_comb begin
        logic [W-1:0] vm;
        n_b.id    = r_a.id;
        n_b.d     = r_a.d;
        n_b.ks    = r_a.ks;
        n_b.gam   = r_a.gam;
        n_b.rest  = r_a.rest;
        n_b.mprod = (2*W-2)'(r_a.ma) * (2*W-2)'(r_a.mb);
        n_b.msum  = W'(r_a.ma) + W'(r_a.mb);
        for (int k = 0; k < 3; k++) begin
            n_b.dm[k]  = r_a.d[k][W-1] ? (~r_a.d[k] + 1'b1) : r_a.d[k];
            vm         = r_a.v[k][W-1] ? (~r_a.v[k] + 1'b1) : r_a.v[k];
            n_b.sgn[k] = r_a.d[k][W-1] ^ r_a.v[k][W-1];
            n_b.sq[k]  = (2*W)'(n_b.dm[k]) * (2*W)'(n_b.dm[k]);
            n_b.pv[k]  = (2*W)'(n_b.dm[k]) * (2*W)'(vm);
        end
    end

    // sums
    always_comb begin
        n_c.id    = r_b.id;
        n_c.d     = r_b.d;
        n_c.dm    = r_b.dm;
        n_c.mprod = r_b.mprod;
        n_c.msum  = r_b.msum;
        n_c.ks    = r_b.ks;
        n_c.gam   = r_b.gam;
        n_c.rest  = r_b.rest;
        n_c_sq    = r_b.sq[0] + r_b.sq[1] + r_b.sq[2];
        n_c.pos   = (r_b.sgn[0] ? '0 : r_b.pv[0]) + (r_b.sgn[1] ? '0 : r_b.pv[1])
                  + (r_b.sgn[2] ? '0 : r_b.pv[2]);
        n_c.neg   = (r_b.sgn[0] ? r_b.pv[0] : '0) + (r_b.sgn[1] ? r_b.pv[1] : '0)
                  + (r_b.sgn[2] ? r_b.pv[2] : '0);
    end

    dsf_sqrt #(
        .RW (W),
        .SW ($bits(t_c))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: en, vld: r_c_vld}),
        .i_rad   (r_c_sq),
        .i_side  (r_c),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side_raw)
    );
    assign sq_side = t_c'(sq_side_raw);

    // softened length, stretch, dot product sign and magnitude
    always_comb begin
        logic [W:0] rest_x;
        rest_x          = (W+1)'(sq_side.rest);
        n_d.len         = (W+1)'(sq_root) + (W+1)'(r_soft);
        n_d.tag.id      = sq_side.id;
        n_d.tag.d       = sq_side.d;
        n_d.tag.sat_len = n_d.len[W];
        n_d.tag.soft_o  = n_d.len[W] ? '1 : n_d.len[W-1:0];
        n_d.tag.s_neg   = n_d.len < rest_x;
        n_d.s_mag       = n_d.tag.s_neg ? rest_x - n_d.len : n_d.len - rest_x;
        n_d.tag.dv_neg  = sq_side.neg > sq_side.pos;
        n_d.dv_mag      = n_d.tag.dv_neg ? sq_side.neg - sq_side.pos
                                         : sq_side.pos - sq_side.neg;
        n_d.dm          = sq_side.dm;
        n_d.mprod       = sq_side.mprod;
        n_d.msum        = sq_side.msum;
        n_d.ks          = sq_side.ks;
        n_d.gam         = sq_side.gam;
    end

    always_comb begin
        n_e.tag    = r_d.tag;
        n_e.dm     = r_d.dm;
        n_e.len    = r_d.len;
        n_e.q      = (2*W)'(r_d.ks) * (2*W)'(r_d.s_mag);
        n_e.dv_mag = r_d.dv_mag;
        n_e.mprod  = r_d.mprod;
        n_e.msum   = r_d.msum;
        n_e.gam    = r_d.gam;
    end

    always_comb begin
        n_f.tag    = r_e.tag;
        n_f.dm     = r_e.dm;
        n_f.len    = r_e.len;
        n_f.dv_mag = r_e.dv_mag;
        n_f.mprod  = r_e.mprod;
        n_f.msum   = r_e.msum;
        n_f.gam    = r_e.gam;
        for (int k = 0; k < 3; k++) begin
            n_f.hi[k] = (2*W)'(r_e.q[2*W-1:W]) * (2*W)'(r_e.dm[k]);
            n_f.lo[k] = (2*W)'(r_e.q[W-1:0]) * (2*W)'(r_e.dm[k]);
        end
    end

    always_comb begin
        n_g.tag    = r_f.tag;
        n_g.dm     = r_f.dm;
        n_g.len    = r_f.len;
        n_g.dv_mag = r_f.dv_mag;
        n_g.mprod  = r_f.mprod;
        n_g.msum   = r_f.msum;
        n_g.gam    = r_f.gam;
        for (int k = 0; k < 3; k++) begin
            n_g.n1[k] = {r_f.hi[k], W'(0)} + (3*W)'(r_f.lo[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d1_num[k] = r_g.n1[k];
            d1_den[k] = r_g.len;
        end
        d1_num[3]            = (3*W)'(r_g.dv_mag);
        d1_den[3]            = r_g.len;
        d1_num[4]            = (3*W)'(r_g.mprod);
        d1_den[4]            = (W+1)'(r_g.msum);
        d1_side_in.tag       = r_g.tag;
        d1_side_in.dm        = r_g.dm;
        d1_side_in.len       = r_g.len;
        d1_side_in.msum_zero = r_g.msum == '0;
        d1_side_in.gam       = r_g.gam;
    end

    dsf_div #(
        .LANES (5),
        .NW    (3*W),
        .DW    (W+1),
        .QW    (2*W),
        .SW    ($bits(t_s1))
    ) u_div_spring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: en, vld: r_g_vld}),
        .i_num   (d1_num),
        .i_den   (d1_den),
        .i_side  (d1_side_in),
        .o_vld   (d1_vld),
        .o_quo   (d1_quo),
        .o_side  (d1_side_raw)
    );
    assign d1_side = t_s1'(d1_side_raw);

    // spring part, reduced mass times damping, r times |d_k|
    always_comb begin
        logic [W-2:0] mbar;
        logic [W:0]   r;
        mbar         = d1_side.msum_zero ? '0 : d1_quo[4][W-2:0];
        r            = d1_quo[3][W:0];
        n_h.tag      = d1_side.tag;
        n_h.len      = d1_side.len;
        n_h.len_zero = d1_side.len == '0;
        n_h.gam_nz   = d1_side.gam != '0;
        n_h.gprod    = (2*W-2)'(d1_side.gam) * (2*W-2)'(mbar);
        for (int k = 0; k < 3; k++) begin
            n_h.dm_zero[k] = d1_side.dm[k] == '0;
            n_h.p[k]       = d1_quo[k] >> F;
            n_h.rdm[k]     = (2*W+1)'(r) * (2*W+1)'(d1_side.dm[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d2_num[k] = r_h.rdm[k];
            d2_den[k] = r_h.len;
        end
        d2_side_in.tag      = r_h.tag;
        d2_side_in.dm_zero  = r_h.dm_zero;
        d2_side_in.len_zero = r_h.len_zero;
        d2_side_in.gam_nz   = r_h.gam_nz;
        d2_side_in.p        = r_h.p;
        d2_side_in.g        = (2*W)'(r_h.gprod >> F);
    end

    dsf_div #(
        .LANES (3),
        .NW    (2*W+1),
        .DW    (W+1),
        .QW    (W+1),
        .SW    ($bits(t_s2))
    ) u_div_damp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   ('{en: en, vld: r_h_vld}),
        .i_num   (d2_num),
        .i_den   (d2_den),
        .i_side  (d2_side_in),
        .o_vld   (d2_vld),
        .o_quo   (d2_quo),
        .o_side  (d2_side_raw)
    );
    assign d2_side = t_s2'(d2_side_raw);

    always_comb begin
        n_j.tag      = d2_side.tag;
        n_j.dm_zero  = d2_side.dm_zero;
        n_j.len_zero = d2_side.len_zero;
        n_j.gam_nz   = d2_side.gam_nz;
        n_j.p        = d2_side.p;
        for (int k = 0; k < 3; k++) begin
            n_j.glo[k] = (2*W+1)'(d2_side.g[W-1:0]) * (2*W+1)'(d2_quo[k]);
            n_j.ghi[k] = (2*W+1)'(d2_side.g[2*W-1:W]) * (2*W+1)'(d2_quo[k]);
        end
    end

    // damping term, clipped when the product leaves the wrap range
    always_comb begin
        logic [3*W:0] prod;
        n_k.tag      = r_j.tag;
        n_k.dm_zero  = r_j.dm_zero;
        n_k.len_zero = r_j.len_zero;
        n_k.gam_nz   = r_j.gam_nz;
        n_k.p        = r_j.p;
        for (int k = 0; k < 3; k++) begin
            prod      = {r_j.ghi[k], W'(0)} + (3*W+1)'(r_j.glo[k]);
            n_k.dd[k] = (|prod[3*W:WRAP_LOG]) ? DAMP_CAP : WRAP_LOG'(prod >> F);
        end
    end

    // combine and saturate
    always_comb begin
        logic [FW-1:0] sp;
        logic [FW-1:0] dp;
        logic [FW-1:0] f;
        logic          dneg;
        logic          sat;
        sat          = r_k.tag.sat_len;
        n_out.id     = r_k.tag.id;
        n_out.lvec   = r_k.tag.d;
        n_out.soft_o = r_k.tag.soft_o;
        for (int k = 0; k < 3; k++) begin
            dneg = r_k.tag.d[k][W-1];
            sp   = (r_k.tag.s_neg != dneg) ? FW'(r_k.p[k]) : FW'(0) - FW'(r_k.p[k]);
            dp   = !r_k.gam_nz ? FW'(0)
                 : (r_k.tag.dv_neg != dneg) ? FW'(r_k.dd[k]) : FW'(0) - FW'(r_k.dd[k]);
            f    = (r_k.len_zero || r_k.dm_zero[k]) ? FW'(0) : sp + dp;
            if (f[FW-1] && !(&f[FW-1:W-1])) begin
                n_out.frc[k] = {1'b1, {(W-1){1'b0}}};
                sat          = 1'b1;
            end else if (!f[FW-1] && (|f[FW-1:W-1])) begin
                n_out.frc[k] = {1'b0, {(W-1){1'b1}}};
                sat          = 1'b1;
            end else begin
                n_out.frc[k] = f[W-1:0];
            end
        end
        n_out.sat = sat;
    end

    assign o_result.valid       = r_out_vld;
    assign o_result.spring_tag  = r_out.id;
    assign o_result.force_x     = r_out.frc[0];
    assign o_result.force_y     = r_out.frc[1];
    assign o_result.force_z     = r_out.frc[2];
    assign o_result.lvec_x      = r_out.lvec[0];
    assign o_result.lvec_y      = r_out.lvec[1];
    assign o_result.lvec_z      = r_out.lvec[2];
    assign o_result.soft_length = r_out.soft_o;
    assign o_result.saturated   = r_out.sat;

endmodule

>>> bench/tb_dsf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bench channel types
// Spring item and force result records used by the damped spring bench.
// ----------------------------------------------------------------------------
package tb_dsf_types;

    typedef struct {
        logic [15:0]        id;
        logic signed [31:0] sx, sy, sz;
        logic signed [31:0] vx, vy, vz;
        logic [30:0]        ma, mb, ks, gam, rest;
    } t_spring;

    typedef struct {
        logic [15:0]        tag;
        logic signed [31:0] fx, fy, fz;
        logic signed [31:0] lx, ly, lz;
        logic [31:0]        len;
        logic               sat;
    } t_force;

endpackage

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Damped spring force unit bench
// Streams directed and random springs through the unit under varying idle
// and stall patterns, predicts each force result in fixed point and checks
// every result field against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_top;
    import tb_dsf_types::*;

    localparam int LATENCY = 140;

    class force_board;
        t_force pending[$];
        int     errors;
        logic [20:0] soft_len;

        function new();
            errors   = 0;
            soft_len = 21'd1;
        endfunction

        static function logic [63:0] isqrt(logic [63:0] x);
            logic [63:0] res, b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= res + b) begin
                    x   = x - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        static function logic [63:0] ratio(logic [63:0] u, logic [63:0] a, logic [63:0] l);
            return (u / l) * a + ((u % l) * a) / l;
        endfunction

        function void note_spring(t_spring s);
            t_force            f;
            logic signed [63:0] d[3], v[3], fk, fmax, fmin;
            logic [63:0]       dm[3], sq, pos, neg, len, smag, q, dvmag, g, r, p, m, dd;
            logic [63:0]       msum, mbar;
            logic              sneg, dvneg, dneg;
            d[0] = s.sx; d[1] = s.sy; d[2] = s.sz;
            v[0] = s.vx; v[1] = s.vy; v[2] = s.vz;
            sq = 0; pos = 0; neg = 0;
            for (int k = 0; k < 3; k++) begin
                dm[k] = d[k] < 0 ? -d[k] : d[k];
                sq = sq + dm[k] * dm[k];
                if ((d[k] < 0) != (v[k] < 0))
                    neg = neg + dm[k] * (v[k] < 0 ? -v[k] : v[k]);
                else
                    pos = pos + dm[k] * (v[k] < 0 ? -v[k] : v[k]);
            end
            len   = isqrt(sq) + soft_len;
            f.sat = len > 64'hFFFF_FFFF;
            f.len = f.sat ? 32'hFFFF_FFFF : len[31:0];
            sneg  = len < s.rest;
            smag  = sneg ? s.rest - len : len - s.rest;
            q     = s.ks * smag;
            dvneg = neg > pos;
            dvmag = dvneg ? neg - pos : pos - neg;
            g = 0; r = 0;
            if (s.gam != 0 && len != 0) begin
                msum = s.ma + s.mb;
                mbar = msum != 0 ? (64'(s.ma) * s.mb) / msum : 0;
                g    = (64'(s.gam) * mbar) >> 20;
                r    = dvmag / len;
            end
            fmax = 64'sh7FFF_FFFF;
            fmin = -fmax - 1;
            for (int k = 0; k < 3; k++) begin
                fk = 0;
                if (len != 0 && dm[k] != 0) begin
                    p    = ratio(q, dm[k], len) >> 20;
                    dneg = d[k] < 0;
                    fk   = (sneg != dneg) ? p : -p;
                    if (s.gam != 0) begin
                        m = ratio(r, dm[k], len);
                        if (m != 0 && g > 64'hFFFF_FFFF_FFFF_FFFF / m) dd = 64'd1 << 45;
                        else dd = (g * m) >> 20;
                        if (dvneg != dneg) fk = fk + dd;
                        else fk = fk - dd;
                    end
                end
                if (fk > fmax) begin
                    fk = fmax; f.sat = 1;
                end else if (fk < fmin) begin
                    fk = fmin; f.sat = 1;
                end
                if (k == 0) f.fx = fk[31:0];
                else if (k == 1) f.fy = fk[31:0];
                else f.fz = fk[31:0];
            end
            f.tag = s.id;
            f.lx = s.sx; f.ly = s.sy; f.lz = s.sz;
            pending.push_back(f);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_force(t_force a);
            t_force e;
            if (pending.size() == 0) begin
                report("unexpected spring_tag", 64'(a.tag), 64'd0);
                return;
            end
            e = pending.pop_front();
            if (a.tag !== e.tag) report("spring_tag", a.tag, e.tag);
            if (a.fx !== e.fx) report("force_x", a.fx, e.fx);
            if (a.fy !== e.fy) report("force_y", a.fy, e.fy);
            if (a.fz !== e.fz) report("force_z", a.fz, e.fz);
            if (a.lx !== e.lx) report("lvec_x", a.lx, e.lx);
            if (a.ly !== e.ly) report("lvec_y", a.ly, e.ly);
            if (a.lz !== e.lz) report("lvec_z", a.lz, e.lz);
            if (a.len !== e.len) report("soft_length", a.len, e.len);
            if (a.sat !== e.sat) report("saturated", a.sat, e.sat);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [20:0] i_cfg_wdata = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_off = 0;
    force_board  board = new();

    dsf_item_if   #(.DATA_WIDTH(32), .ID_WIDTH(16)) item_ch ();
    dsf_result_if #(.DATA_WIDTH(32), .ID_WIDTH(16)) result_ch ();

    damped_spring_force_unit #(.DATA_WIDTH(32), .FRAC_BITS(20), .ID_WIDTH(16)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch.sink),
        .o_result    (result_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        item_ch.valid = 0;
        item_ch.spring_id = 0;
        item_ch.sep_x = 0; item_ch.sep_y = 0; item_ch.sep_z = 0;
        item_ch.relvel_x = 0; item_ch.relvel_y = 0; item_ch.relvel_z = 0;
        item_ch.mass_a = 1; item_ch.mass_b = 1;
        item_ch.stiffness = 0; item_ch.damping = 0; item_ch.rest_len = 0;
        result_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 0;
        end else if (hold_off > 0) begin
            hold_off        <= hold_off - 1;
            result_ch.ready <= 0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_force a;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            a.tag = result_ch.spring_tag;
            a.fx = result_ch.force_x; a.fy = result_ch.force_y; a.fz = result_ch.force_z;
            a.lx = result_ch.lvec_x; a.ly = result_ch.lvec_y; a.lz = result_ch.lvec_z;
            a.len = result_ch.soft_length;
            a.sat = result_ch.saturated;
            board.check_force(a);
        end
    end

    function automatic logic signed [31:0] rand_comp(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(4194304)) - 2097152;
            default: return $signed($urandom_range(65536)) - 32768;
        endcase
    endfunction

    function automatic t_spring rand_spring();
        t_spring s;
        int      mode;
        mode   = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
        s.id   = 16'($urandom);
        s.sx   = rand_comp(mode); s.sy = rand_comp(mode); s.sz = rand_comp(mode);
        s.vx   = rand_comp(mode); s.vy = rand_comp(mode); s.vz = rand_comp(mode);
        s.ma   = $urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(8388608));
        s.mb   = $urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(8388608));
        if (s.ma == 0) s.ma = 1;
        if (s.mb == 0) s.mb = 1;
        s.ks   = $urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(20971520));
        s.gam  = $urandom_range(3) == 0 ? 31'd0 :
                 ($urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(4194304)));
        s.rest = $urandom_range(9) == 0 ? 31'($urandom) : 31'($urandom_range(8388608));
        return s;
    endfunction

    task automatic send_spring(t_spring s);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            item_ch.valid <= 0;
            @(posedge i_clk);
        end
        item_ch.valid     <= 1;
        item_ch.spring_id <= s.id;
        item_ch.sep_x <= s.sx; item_ch.sep_y <= s.sy; item_ch.sep_z <= s.sz;
        item_ch.relvel_x <= s.vx; item_ch.relvel_y <= s.vy; item_ch.relvel_z <= s.vz;
        item_ch.mass_a <= s.ma; item_ch.mass_b <= s.mb;
        item_ch.stiffness <= s.ks; item_ch.damping <= s.gam; item_ch.rest_len <= s.rest;
        do @(posedge i_clk); while (!item_ch.ready);
        board.note_spring(s);
    endtask

    task automatic drain();
        item_ch.valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_soft(logic [20:0] val);
        i_cfg_we    <= 1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 0;
        board.soft_len = val;
    endtask

    initial begin
        t_spring s;
        logic signed [31:0] ext[4];
        ext[0] = 32'sh8000_0000; ext[1] = 32'sh7FFF_FFFF; ext[2] = 0; ext[3] = -1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero length, extremes, dead spring, saturation
        for (int n = 0; n < 20; n++) begin
            s = rand_spring();
            s.sx = ext[n % 4]; s.sy = ext[(n / 4) % 4]; s.sz = ext[(n + 1) % 4];
            s.vx = ext[(n + 2) % 4]; s.vy = ext[n % 4]; s.vz = ext[(n + 3) % 4];
            s.ma = n % 3 == 0 ? 31'h7FFF_FFFF : 31'd1;
            s.mb = n % 2 == 0 ? 31'h7FFF_FFFF : 31'd1;
            s.ks = n % 5 == 0 ? 31'd0 : (n % 2 ? 31'h7FFF_FFFF : 31'd1048576);
            s.gam = n % 4 == 0 ? 31'd0 : (n % 3 ? 31'h7FFF_FFFF : 31'd1);
            s.rest = n % 3 == 0 ? 31'h7FFF_FFFF : 31'd0;
            s.id = n % 2 ? 16'hFFFF : 16'h0000;
            if (n == 19) begin
                s.sx = 0; s.sy = 0; s.sz = 0;
            end
            send_spring(s);
        end
        drain();
        write_soft(21'd0);
        s = rand_spring();
        s.sx = 0; s.sy = 0; s.sz = 0;
        send_spring(s);
        send_spring(rand_spring());
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  write_soft(21'd1048576); end
                1: begin idle_pct = 58; stall_pct = 0;  write_soft(21'h1FFFFF); end
                2: begin idle_pct = 0;  stall_pct = 58; write_soft(21'd1); end
                3: begin idle_pct = 20; stall_pct = 20; write_soft(21'($urandom)); end
                4: begin idle_pct = 0;  stall_pct = 0;  write_soft(21'd0); end
                default: begin idle_pct = 20; stall_pct = 58; write_soft(21'd1024); end
            endcase
            if (ph == 4) hold_off = 400;
            for (int n = 0; n < 105; n++) begin
                if (ph == 3 && n == 50) begin
                    item_ch.valid <= 0;
                    while (board.pending.size() != 0) @(posedge i_clk);
                end
                send_spring(rand_spring());
            end
            drain();
        end
        if (board.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/dsf_pkg.sv
rtl/dsf_item_if.sv
rtl/dsf_result_if.sv
rtl/dsf_sqrt.sv
rtl/dsf_div.sv
rtl/damped_spring_force_unit.sv
bench/tb_dsf_if.sv
bench/tb_top.sv
